// ===== rtl/core/psbss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psbss_pkg: shared types and helpers for the point set split search
// Sizes, the command and status records between controller and datapath,
// and the bounding rectangle arithmetic.
// ----------------------------------------------------------------------------
package psbss_pkg;

  localparam int MAX_POINTS  = 64;
  localparam int COORD_BITS  = 16;
  localparam int IN_W        = 16;
  localparam int IDX_W       = $clog2(MAX_POINTS);
  localparam int CNT_W       = $clog2(MAX_POINTS + 1);
  localparam int INDEX_OUT_W = 6;
  localparam int SPAN_W      = COORD_BITS + 1;
  localparam int PROD_W      = 2 * SPAN_W;
  localparam int AREA_W      = 34;
  localparam int WIDE_W      = ((PROD_W > AREA_W) ? PROD_W : AREA_W) + 1;
  localparam int GAIN_W      = 17;
  localparam int FRAC_W      = 16;
  localparam int HALF_W      = AREA_W / 2;
  localparam int QUAL_W      = AREA_W + GAIN_W + 1;

  localparam logic [AREA_W-1:0] AREA_MAX   = {AREA_W{1'b1}};
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(62259);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [AREA_W-1:0] area_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    logic   v;
    coord_t lo0;
    coord_t hi0;
    coord_t lo1;
    coord_t hi1;
  } rect_t;

  typedef enum logic [1:0] {
    PLANE_XY,
    PLANE_XZ,
    PLANE_YZ
  } plane_e;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_TOTAL,
    ACC_CUT,
    ACC_PAIR
  } acc_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_TOT_AREA,
    OP_PLANE_INIT,
    OP_PAIR_AREA,
    OP_PAIR_UPD,
    OP_QUAL_LO,
    OP_QUAL_HI,
    OP_QUAL_FIN,
    OP_SELECT
  } op_e;

  typedef enum logic [1:0] {
    OUT_NOP,
    OUT_NONE,
    OUT_POINT
  } out_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_START,
    S_PLANE,
    S_TOT_SCAN,
    S_TOT_DRAIN,
    S_TOT_AREA,
    S_PLANE_INIT,
    S_CUT_RD,
    S_PAIR_SCAN,
    S_PAIR_DRAIN,
    S_PAIR_AREA,
    S_PAIR_UPD,
    S_QUAL_LO,
    S_QUAL_HI,
    S_QUAL_FIN,
    S_SELECT,
    S_EMIT_SEL,
    S_EMIT_RD,
    S_EMIT_LD,
    S_EMIT_NONE,
    S_EMIT_WAIT,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic             load;
    logic             clear_set;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    acc_e             acc;
    logic             clr_acc;
    op_e              op;
    plane_e           plane;
    logic             dir;
    logic [IDX_W-1:0] k;
    out_e             out_op;
    logic [IDX_W-1:0] out_index;
    logic             out_last;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             sel_valid;
    logic             out_accept;
    logic             out_last;
  } stat_t;

  function automatic coord_t axis_a(point_t p, plane_e pl);
    case (pl)
      PLANE_YZ: return p.y;
      default:  return p.x;
    endcase
  endfunction

  function automatic coord_t axis_b(point_t p, plane_e pl);
    case (pl)
      PLANE_XY: return p.y;
      default:  return p.z;
    endcase
  endfunction

  // direction 0 cuts on the plane's second axis, 1 on its first
  function automatic coord_t cut_axis(point_t p, plane_e pl, logic dir);
    return dir ? axis_a(p, pl) : axis_b(p, pl);
  endfunction

  function automatic rect_t rect_add(rect_t r, coord_t u, coord_t w);
    rect_t o;
    o = r;
    if (!r.v) begin
      o.lo0 = u;
      o.hi0 = u;
      o.lo1 = w;
      o.hi1 = w;
    end else begin
      if (u < r.lo0) o.lo0 = u;
      if (u > r.hi0) o.hi0 = u;
      if (w < r.lo1) o.lo1 = w;
      if (w > r.hi1) o.hi1 = w;
    end
    o.v = 1'b1;
    return o;
  endfunction

  function automatic area_t rect_area(rect_t r);
    logic [SPAN_W-1:0] w;
    logic [SPAN_W-1:0] h;
    logic [PROD_W-1:0] p;
    logic [WIDE_W-1:0] pw;
    w  = {r.hi0[COORD_BITS-1], r.hi0} - {r.lo0[COORD_BITS-1], r.lo0};
    h  = {r.hi1[COORD_BITS-1], r.hi1} - {r.lo1[COORD_BITS-1], r.lo1};
    p  = PROD_W'(w) * PROD_W'(h);
    pw = WIDE_W'(p);
    if (!r.v) return '0;
    if (pw > WIDE_W'(AREA_MAX)) return AREA_MAX;
    return AREA_W'(pw);
  endfunction

  function automatic area_t sat_add(area_t a, area_t b);
    logic [AREA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[AREA_W] ? AREA_MAX : s[AREA_W-1:0];
  endfunction

endpackage

// ===== rtl/core/point_set_best_split_search_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_set_best_split_search_core: best axis-aligned split of a point set
// Loads points, searches three projection planes for the cheapest cut and
// streams one side bit per point, or a single no-split result.
// ----------------------------------------------------------------------------
// Loading: one point per cycle while idle, no result for a non-final point.
// Search: per plane a scan for the total box, then 2*N cut candidates, each
//   a full scan of the set, then qualification; paced by the
//   single read port of the point memory. Fewer than two points skip it.
// Results: each is read, loaded and held until taken; the set is cleared before rearming.
// Reset: control cleared asynchronously; point memory is not cleared.
module point_set_best_split_search_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [psbss_pkg::GAIN_W-1:0]        cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [psbss_pkg::IN_W-1:0]   point_x_i,
  input  logic signed [psbss_pkg::IN_W-1:0]   point_y_i,
  input  logic signed [psbss_pkg::IN_W-1:0]   point_z_i,
  input  logic                                last_point_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                split_found_o,
  output logic [1:0]                          plane_used_o,
  output logic                                cut_direction_o,
  output logic [psbss_pkg::AREA_W-1:0]        best_area_o,
  output logic [psbss_pkg::INDEX_OUT_W-1:0]   point_index_o,
  output logic                                side_o,
  output logic                                overflow_o,
  output logic                                last_result_o
);

  psbss_pkg::cmd_t  cmd;
  psbss_pkg::stat_t stat;

  // sequencer: owns the loops and the request handshake on the input side
  psbss_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .last_point_i (last_point_i),
    .in_ready_o   (in_ready_o),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  // datapath: memory, accumulators, arithmetic and the result register
  psbss_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .point_x_i       (point_x_i),
    .point_y_i       (point_y_i),
    .point_z_i       (point_z_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .split_found_o   (split_found_o),
    .plane_used_o    (plane_used_o),
    .cut_direction_o (cut_direction_o),
    .best_area_o     (best_area_o),
    .point_index_o   (point_index_o),
    .side_o          (side_o),
    .overflow_o      (overflow_o),
    .last_result_o   (last_result_o)
  );

  // hold off new requests while any result of the run is pending
  a_no_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is pending");

  // a final point starts the search and closes the input side
  a_last_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && last_point_i) |=> !in_ready_o)
    else $error("input still ready after final point");

  // taking the final result empties the output side
  a_last_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_result_o) |=> !out_valid_o)
    else $error("result still valid after final result taken");

endmodule

// ===== rtl/core/psbss_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psbss_ctrl: search sequencer
// Walks planes, directions, cut candidates and scan positions, and issues
// read, accumulate and arithmetic commands to the datapath.
// ----------------------------------------------------------------------------
module psbss_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             last_point_i,
  output logic             in_ready_o,
  input  psbss_pkg::stat_t stat_i,
  output psbss_pkg::cmd_t  cmd_o
);

  psbss_pkg::state_e state_q, state_d;
  psbss_pkg::plane_e plane_q, plane_d;
  logic dir_q, dir_d;
  logic [psbss_pkg::IDX_W-1:0] k_q, k_d;
  logic [psbss_pkg::IDX_W-1:0] t_q, t_d;
  logic in_accept;
  logic t_last;
  logic k_last;

  assign in_ready_o = (state_q == psbss_pkg::S_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign t_last = ((psbss_pkg::CNT_W'(t_q) + psbss_pkg::CNT_W'(1)) == stat_i.count);
  assign k_last = ((psbss_pkg::CNT_W'(k_q) + psbss_pkg::CNT_W'(1)) == stat_i.count);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= psbss_pkg::S_IDLE;
      plane_q <= psbss_pkg::PLANE_XY;
      dir_q   <= 1'b0;
      k_q     <= '0;
      t_q     <= '0;
    end else begin
      state_q <= state_d;
      plane_q <= plane_d;
      dir_q   <= dir_d;
      k_q     <= k_d;
      t_q     <= t_d;
    end
  end

  // next state and loop counters
  always_comb begin
    state_d = state_q;
    plane_d = plane_q;
    dir_d   = dir_q;
    k_d     = k_q;
    t_d     = t_q;
    case (state_q)
      psbss_pkg::S_IDLE: begin
        if (in_accept && last_point_i) state_d = psbss_pkg::S_START;
      end
      psbss_pkg::S_START: begin
        if (stat_i.count < psbss_pkg::CNT_W'(2)) begin
          state_d = psbss_pkg::S_EMIT_NONE;
        end else begin
          plane_d = psbss_pkg::PLANE_XY;
          state_d = psbss_pkg::S_PLANE;
        end
      end
      psbss_pkg::S_PLANE: begin
        t_d     = '0;
        state_d = psbss_pkg::S_TOT_SCAN;
      end
      psbss_pkg::S_TOT_SCAN: begin
        if (t_last) state_d = psbss_pkg::S_TOT_DRAIN;
        else t_d = t_q + 1'b1;
      end
      psbss_pkg::S_TOT_DRAIN: state_d = psbss_pkg::S_TOT_AREA;
      psbss_pkg::S_TOT_AREA:  state_d = psbss_pkg::S_PLANE_INIT;
      psbss_pkg::S_PLANE_INIT: begin
        dir_d   = 1'b0;
        k_d     = '0;
        state_d = psbss_pkg::S_CUT_RD;
      end
      psbss_pkg::S_CUT_RD: begin
        t_d     = '0;
        state_d = psbss_pkg::S_PAIR_SCAN;
      end
      psbss_pkg::S_PAIR_SCAN: begin
        if (t_last) state_d = psbss_pkg::S_PAIR_DRAIN;
        else t_d = t_q + 1'b1;
      end
      psbss_pkg::S_PAIR_DRAIN: state_d = psbss_pkg::S_PAIR_AREA;
      psbss_pkg::S_PAIR_AREA:  state_d = psbss_pkg::S_PAIR_UPD;
      psbss_pkg::S_PAIR_UPD: begin
        if (!k_last) begin
          k_d     = k_q + 1'b1;
          state_d = psbss_pkg::S_CUT_RD;
        end else if (!dir_q) begin
          dir_d   = 1'b1;
          k_d     = '0;
          state_d = psbss_pkg::S_CUT_RD;
        end else begin
          state_d = psbss_pkg::S_QUAL_LO;
        end
      end
      psbss_pkg::S_QUAL_LO: state_d = psbss_pkg::S_QUAL_HI;
      psbss_pkg::S_QUAL_HI: state_d = psbss_pkg::S_QUAL_FIN;
      psbss_pkg::S_QUAL_FIN: begin
        case (plane_q)
          psbss_pkg::PLANE_XY: begin
            plane_d = psbss_pkg::PLANE_XZ;
            state_d = psbss_pkg::S_PLANE;
          end
          psbss_pkg::PLANE_XZ: begin
            plane_d = psbss_pkg::PLANE_YZ;
            state_d = psbss_pkg::S_PLANE;
          end
          default: state_d = psbss_pkg::S_SELECT;
        endcase
      end
      psbss_pkg::S_SELECT: state_d = psbss_pkg::S_EMIT_SEL;
      psbss_pkg::S_EMIT_SEL: begin
        t_d     = '0;
        state_d = stat_i.sel_valid ? psbss_pkg::S_EMIT_RD : psbss_pkg::S_EMIT_NONE;
      end
      psbss_pkg::S_EMIT_RD:   state_d = psbss_pkg::S_EMIT_LD;
      psbss_pkg::S_EMIT_LD:   state_d = psbss_pkg::S_EMIT_WAIT;
      psbss_pkg::S_EMIT_NONE: state_d = psbss_pkg::S_EMIT_WAIT;
      psbss_pkg::S_EMIT_WAIT: begin
        if (stat_i.out_accept) begin
          if (stat_i.out_last) begin
            state_d = psbss_pkg::S_FINISH;
          end else begin
            t_d     = t_q + 1'b1;
            state_d = psbss_pkg::S_EMIT_RD;
          end
        end
      end
      psbss_pkg::S_FINISH: state_d = psbss_pkg::S_IDLE;
      default: state_d = psbss_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o           = '0;
    cmd_o.acc       = psbss_pkg::ACC_NONE;
    cmd_o.op        = psbss_pkg::OP_NONE;
    cmd_o.out_op    = psbss_pkg::OUT_NOP;
    cmd_o.plane     = plane_q;
    cmd_o.dir       = dir_q;
    cmd_o.k         = k_q;
    cmd_o.rd_addr   = t_q;
    cmd_o.out_index = t_q;
    cmd_o.out_last  = t_last;
    cmd_o.load      = in_accept;
    case (state_q)
      psbss_pkg::S_PLANE: cmd_o.clr_acc = 1'b1;
      psbss_pkg::S_TOT_SCAN: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.acc   = psbss_pkg::ACC_TOTAL;
      end
      psbss_pkg::S_TOT_AREA:   cmd_o.op = psbss_pkg::OP_TOT_AREA;
      psbss_pkg::S_PLANE_INIT: cmd_o.op = psbss_pkg::OP_PLANE_INIT;
      psbss_pkg::S_CUT_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = k_q;
        cmd_o.acc     = psbss_pkg::ACC_CUT;
        cmd_o.clr_acc = 1'b1;
      end
      psbss_pkg::S_PAIR_SCAN: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.acc   = psbss_pkg::ACC_PAIR;
      end
      psbss_pkg::S_PAIR_AREA: cmd_o.op = psbss_pkg::OP_PAIR_AREA;
      psbss_pkg::S_PAIR_UPD:  cmd_o.op = psbss_pkg::OP_PAIR_UPD;
      psbss_pkg::S_QUAL_LO:   cmd_o.op = psbss_pkg::OP_QUAL_LO;
      psbss_pkg::S_QUAL_HI:   cmd_o.op = psbss_pkg::OP_QUAL_HI;
      psbss_pkg::S_QUAL_FIN:  cmd_o.op = psbss_pkg::OP_QUAL_FIN;
      psbss_pkg::S_SELECT:    cmd_o.op = psbss_pkg::OP_SELECT;
      psbss_pkg::S_EMIT_RD:   cmd_o.rd_en = 1'b1;
      psbss_pkg::S_EMIT_LD:   cmd_o.out_op = psbss_pkg::OUT_POINT;
      psbss_pkg::S_EMIT_NONE: cmd_o.out_op = psbss_pkg::OUT_NONE;
      psbss_pkg::S_FINISH:    cmd_o.clear_set = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/psbss_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psbss_dp: search datapath
// Point memory, rectangle accumulators, area multipliers, best-cut tracking,
// plane qualification and selection, and the result register.
// ----------------------------------------------------------------------------
module psbss_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  psbss_pkg::cmd_t                     cmd_i,
  output psbss_pkg::stat_t                    stat_o,
  input  logic                                cfg_we_i,
  input  logic [psbss_pkg::GAIN_W-1:0]        cfg_wdata_i,
  input  logic signed [psbss_pkg::IN_W-1:0]   point_x_i,
  input  logic signed [psbss_pkg::IN_W-1:0]   point_y_i,
  input  logic signed [psbss_pkg::IN_W-1:0]   point_z_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic                                split_found_o,
  output logic [1:0]                          plane_used_o,
  output logic                                cut_direction_o,
  output logic [psbss_pkg::AREA_W-1:0]        best_area_o,
  output logic [psbss_pkg::INDEX_OUT_W-1:0]   point_index_o,
  output logic                                side_o,
  output logic                                overflow_o,
  output logic                                last_result_o
);

  psbss_pkg::point_t mem [psbss_pkg::MAX_POINTS];
  psbss_pkg::point_t rd_data_q;
  psbss_pkg::point_t wr_point;

  logic [psbss_pkg::CNT_W-1:0]  count_q;
  logic                         ovf_q;
  logic [psbss_pkg::GAIN_W-1:0] gain_q;

  logic                         rv_q;
  psbss_pkg::acc_e              racc_q;
  logic [psbss_pkg::IDX_W-1:0]  raddr_q;

  psbss_pkg::rect_t all_q, up_q, dn_q;
  psbss_pkg::coord_t cut_q;
  psbss_pkg::area_t  area_up_q, area_dn_q;
  psbss_pkg::area_t  total_q, best_q;
  logic              found_q;
  logic              bdir_q;
  psbss_pkg::coord_t bcut_q;
  logic [2*psbss_pkg::HALF_W-1:0] qlo_q, qhi_q;

  logic              pl_qual_q [3];
  psbss_pkg::area_t  pl_area_q [3];
  logic              pl_dir_q  [3];
  psbss_pkg::coord_t pl_cut_q  [3];
  logic              sel_v_q;
  logic [1:0]        sel_q;

  logic              out_valid_q;
  logic              o_found_q, o_dir_q, o_side_q, o_ovf_q, o_last_q;
  logic [1:0]        o_plane_q;
  psbss_pkg::area_t  o_area_q;
  logic [psbss_pkg::IDX_W-1:0] o_index_q;

  psbss_pkg::coord_t         pair_u, pair_v, pair_c, rd_cut, emit_c;
  psbss_pkg::area_t          pair_sum;
  logic [psbss_pkg::QUAL_W-1:0] q_lhs, q_rhs;
  logic                      sel_v_d;
  logic [1:0]                sel_d;
  psbss_pkg::plane_e         sel_plane;
  logic                      out_accept;

  assign wr_point.x = psbss_pkg::coord_t'(point_x_i);
  assign wr_point.y = psbss_pkg::coord_t'(point_y_i);
  assign wr_point.z = psbss_pkg::coord_t'(point_z_i);

  assign out_accept = out_valid_q && out_ready_i;

  assign pair_u   = psbss_pkg::axis_a(rd_data_q, cmd_i.plane);
  assign pair_v   = psbss_pkg::axis_b(rd_data_q, cmd_i.plane);
  assign pair_c   = psbss_pkg::cut_axis(rd_data_q, cmd_i.plane, cmd_i.dir);
  assign rd_cut   = pair_c;
  assign pair_sum = psbss_pkg::sat_add(area_up_q, area_dn_q);

  assign sel_plane = psbss_pkg::plane_e'(sel_q);
  assign emit_c    = psbss_pkg::cut_axis(rd_data_q, sel_plane, pl_dir_q[sel_q]);

  // best * 2^16 against gain * total, with the product built from two halves
  assign q_lhs = psbss_pkg::QUAL_W'({best_q, {psbss_pkg::FRAC_W{1'b0}}});
  assign q_rhs = psbss_pkg::QUAL_W'({qhi_q, {psbss_pkg::HALF_W{1'b0}}})
               + psbss_pkg::QUAL_W'(qlo_q);

  always_comb begin
    sel_v_d = 1'b0;
    sel_d   = 2'd0;
    for (int p = 0; p < 3; p++) begin
      if (pl_qual_q[p] && (!sel_v_d || pl_area_q[p] < pl_area_q[sel_d])) begin
        sel_v_d = 1'b1;
        sel_d   = 2'(p);
      end
    end
  end

  // point memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && count_q < psbss_pkg::CNT_W'(psbss_pkg::MAX_POINTS)) begin
      mem[count_q[psbss_pkg::IDX_W-1:0]] <= wr_point;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[cmd_i.rd_addr];
    end
  end

  // set bookkeeping, gain register, read tag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      gain_q  <= psbss_pkg::GAIN_RESET;
      rv_q    <= 1'b0;
      racc_q  <= psbss_pkg::ACC_NONE;
    end else begin
      if (cfg_we_i) gain_q <= cfg_wdata_i;
      if (cmd_i.clear_set) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
      end else if (cmd_i.load) begin
        if (count_q < psbss_pkg::CNT_W'(psbss_pkg::MAX_POINTS)) count_q <= count_q + 1'b1;
        else ovf_q <= 1'b1;
      end
      rv_q   <= cmd_i.rd_en;
      racc_q <= cmd_i.acc;
    end
  end

  always_ff @(posedge clk_i) begin
    raddr_q <= cmd_i.rd_addr;
  end

  // accumulators and search arithmetic
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      all_q.v <= 1'b0;
      up_q.v  <= 1'b0;
      dn_q.v  <= 1'b0;
      found_q <= 1'b0;
      for (int p = 0; p < 3; p++) pl_qual_q[p] <= 1'b0;
      sel_v_q <= 1'b0;
    end else begin
      if (cmd_i.clr_acc) begin
        all_q.v <= 1'b0;
        up_q.v  <= 1'b0;
        dn_q.v  <= 1'b0;
      end
      if (rv_q) begin
        case (racc_q)
          psbss_pkg::ACC_TOTAL: all_q <= psbss_pkg::rect_add(all_q, pair_u, pair_v);
          psbss_pkg::ACC_CUT:   cut_q <= rd_cut;
          psbss_pkg::ACC_PAIR: begin
            // skip the cut point itself
            if (raddr_q != cmd_i.k) begin
              if (pair_c > cut_q) up_q <= psbss_pkg::rect_add(up_q, pair_u, pair_v);
              else dn_q <= psbss_pkg::rect_add(dn_q, pair_u, pair_v);
            end
          end
          default: ;
        endcase
      end
      case (cmd_i.op)
        psbss_pkg::OP_TOT_AREA: area_up_q <= psbss_pkg::rect_area(all_q);
        psbss_pkg::OP_PLANE_INIT: begin
          total_q <= area_up_q;
          best_q  <= area_up_q;
          found_q <= 1'b0;
          bdir_q  <= 1'b0;
          bcut_q  <= '0;
        end
        psbss_pkg::OP_PAIR_AREA: begin
          area_up_q <= psbss_pkg::rect_area(up_q);
          area_dn_q <= psbss_pkg::rect_area(dn_q);
        end
        psbss_pkg::OP_PAIR_UPD: begin
          if (up_q.v && dn_q.v && pair_sum < best_q) begin
            best_q  <= pair_sum;
            found_q <= 1'b1;
            bdir_q  <= cmd_i.dir;
            bcut_q  <= cut_q;
          end
        end
        psbss_pkg::OP_QUAL_LO: qlo_q <= gain_q * total_q[psbss_pkg::HALF_W-1:0];
        psbss_pkg::OP_QUAL_HI:
          qhi_q <= gain_q * total_q[psbss_pkg::AREA_W-1:psbss_pkg::HALF_W];
        psbss_pkg::OP_QUAL_FIN: begin
          pl_qual_q[cmd_i.plane] <= found_q && (q_lhs < q_rhs);
          pl_area_q[cmd_i.plane] <= best_q;
          pl_dir_q[cmd_i.plane]  <= bdir_q;
          pl_cut_q[cmd_i.plane]  <= bcut_q;
        end
        psbss_pkg::OP_SELECT: begin
          sel_v_q <= sel_v_d;
          sel_q   <= sel_d;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.out_op != psbss_pkg::OUT_NOP) out_valid_q <= 1'b1;
      else if (out_accept) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.out_op)
      psbss_pkg::OUT_NONE: begin
        o_found_q <= 1'b0;
        o_plane_q <= 2'd0;
        o_dir_q   <= 1'b0;
        o_area_q  <= '0;
        o_index_q <= '0;
        o_side_q  <= 1'b0;
        o_ovf_q   <= ovf_q;
        o_last_q  <= 1'b1;
      end
      psbss_pkg::OUT_POINT: begin
        o_found_q <= 1'b1;
        o_plane_q <= sel_q;
        o_dir_q   <= pl_dir_q[sel_q];
        o_area_q  <= pl_area_q[sel_q];
        o_index_q <= cmd_i.out_index;
        o_side_q  <= (emit_c < pl_cut_q[sel_q]);
        o_ovf_q   <= ovf_q;
        o_last_q  <= cmd_i.out_last;
      end
      default: ;
    endcase
  end

  assign stat_o.count      = count_q;
  assign stat_o.sel_valid  = sel_v_q;
  assign stat_o.out_accept = out_accept;
  assign stat_o.out_last   = o_last_q;

  assign out_valid_o     = out_valid_q;
  assign split_found_o   = o_found_q;
  assign plane_used_o    = o_plane_q;
  assign cut_direction_o = o_dir_q;
  assign best_area_o     = o_area_q;
  assign point_index_o   = psbss_pkg::INDEX_OUT_W'(o_index_q);
  assign side_o          = o_side_q;
  assign overflow_o      = o_ovf_q;
  assign last_result_o   = o_last_q;

endmodule
